@@ src/spr_pkg.sv @@
// Shared types and constants for the slotted page record store.
// Holds page geometry, command and status codes, the sequencer state type
// and the request/result structs. No dependencies.
package spr_pkg;

  localparam int PAGE_BYTES       = 4096;
  localparam int META_BYTES       = 4;
  localparam int SLOT_ENTRY_BYTES = 4;
  localparam int MAX_SLOTS        = 1024;
  localparam int FIRST_OFFSET     = 0;

  localparam int PAGE_AW = $clog2(PAGE_BYTES);
  localparam int POS_W   = PAGE_AW + 1;
  localparam int SLOT_AW = $clog2(MAX_SLOTS);
  localparam int CNT_W   = SLOT_AW + 1;

  localparam logic [2:0] CMD_ALLOC  = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_ERASE  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_RANGE   = 3'd2;
  localparam logic [2:0] ST_DELETED = 3'd3;
  localparam logic [2:0] ST_INDEX   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_MOVE,
    S_ADJ,
    S_COMMIT,
    S_RDATA
  } state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [9:0]  slot;
    logic [11:0] byte_index;
    logic [11:0] record_length;
    logic [7:0]  data_in;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot_out;
    logic [7:0]  data_out;
    logic [11:0] length_out;
    logic [11:0] free_bytes;
    logic [10:0] slots_used;
  } res_t;

endpackage

@@ src/slotted_page_record_store_unit.sv @@
// Slotted page record store: top level with directory, page store and sequencer.
// Depends on spr_pkg and spr_ram.
//
// One command is taken when start is high and busy is low; its result appears
// on result for exactly one cycle with done high and cannot be held off.
// Allocate scans the directory for a free slot and appends one if none is
// found; when it reuses a slot it shifts the later bytes right and rebases
// the later slots. Delete shifts the later bytes left and rebases the later
// slots. Byte moves use the single page-store port pair, which moves one byte
// per cycle, and rebasing uses the directory port pair, which reads and
// rewrites one slot entry per cycle.
module slotted_page_record_store_unit
  import spr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output res_t result
);

  state_t state, state_next;
  req_t   req, req_next;

  logic [POS_W-1:0] rec_end, rec_end_next;
  logic [POS_W-1:0] free_count, free_count_next;
  logic [CNT_W-1:0] slot_total, slot_total_next;

  logic [SLOT_AW-1:0] cur_s, cur_s_next;
  logic [POS_W-1:0]   cur_len, cur_len_next;
  logic [POS_W-1:0]   start_pos, start_pos_next;
  logic               append, append_next;
  logic [SLOT_AW-1:0] scan_ptr, scan_ptr_next;

  logic [POS_W-1:0]   src, src_next, dst, dst_next, cnt, cnt_next;
  logic               move_left, move_left_next;
  logic               mv_pend, mv_pend_next;
  logic [PAGE_AW-1:0] mv_waddr, mv_waddr_next;

  logic [CNT_W-1:0]   adj_ptr, adj_ptr_next;
  logic               adj_pend, adj_pend_next;
  logic [SLOT_AW-1:0] adj_waddr, adj_waddr_next;

  logic        done_next;
  logic [2:0]  res_status, res_status_next;
  logic [9:0]  res_slot, res_slot_next;
  logic [7:0]  res_data, res_data_next;
  logic [11:0] res_len, res_len_next;

  logic               page_we;
  logic [PAGE_AW-1:0] page_waddr, page_raddr;
  logic [7:0]         page_wdata, page_rd;

  logic               off_we, len_we;
  logic [SLOT_AW-1:0] dir_waddr, dir_raddr;
  logic [PAGE_AW-1:0] off_wdata, off_rd;
  logic [POS_W-1:0]   len_wdata, len_rd;

  logic [POS_W-1:0] rlen, need, from_pos, span, addr;
  logic [POS_W:0]   alloc_end;

  spr_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page (
    .clk(clk), .we(page_we), .waddr(page_waddr), .wdata(page_wdata),
    .raddr(page_raddr), .rdata(page_rd)
  );

  spr_ram #(.WIDTH(PAGE_AW), .DEPTH(MAX_SLOTS)) u_offs (
    .clk(clk), .we(off_we), .waddr(dir_waddr), .wdata(off_wdata),
    .raddr(dir_raddr), .rdata(off_rd)
  );

  spr_ram #(.WIDTH(POS_W), .DEPTH(MAX_SLOTS)) u_lens (
    .clk(clk), .we(len_we), .waddr(dir_waddr), .wdata(len_wdata),
    .raddr(dir_raddr), .rdata(len_rd)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    result.status     = res_status;
    result.slot_out   = res_slot;
    result.data_out   = res_data;
    result.length_out = res_len;
    result.free_bytes = free_count[11:0];
    result.slots_used = slot_total;
  end

  always_comb begin
    rlen      = POS_W'(req.record_length);
    need      = rlen + POS_W'(SLOT_ENTRY_BYTES);
    alloc_end = {1'b0, rec_end} + {1'b0, rlen};
    from_pos  = POS_W'(off_rd) + len_rd;
    span      = rec_end - from_pos;
    addr      = POS_W'(off_rd) + POS_W'(req.byte_index);

    state_next      = state;
    req_next        = req;
    rec_end_next    = rec_end;
    free_count_next = free_count;
    slot_total_next = slot_total;
    cur_s_next      = cur_s;
    cur_len_next    = cur_len;
    start_pos_next  = start_pos;
    append_next     = append;
    scan_ptr_next   = scan_ptr;
    src_next        = src;
    dst_next        = dst;
    cnt_next        = cnt;
    move_left_next  = move_left;
    mv_pend_next    = mv_pend;
    mv_waddr_next   = mv_waddr;
    adj_ptr_next    = adj_ptr;
    adj_pend_next   = adj_pend;
    adj_waddr_next  = adj_waddr;
    done_next       = 1'b0;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_data_next   = res_data;
    res_len_next    = res_len;

    page_we    = 1'b0;
    page_waddr = '0;
    page_wdata = '0;
    page_raddr = '0;
    off_we     = 1'b0;
    len_we     = 1'b0;
    dir_waddr  = '0;
    off_wdata  = '0;
    len_wdata  = '0;
    dir_raddr  = SLOT_AW'(req.slot);

    unique case (state)
      S_IDLE: begin
        dir_raddr = SLOT_AW'(request.slot);
        if (start) begin
          req_next   = request;
          state_next = S_LOOK;
        end
      end

      S_LOOK: begin
        done_next       = 1'b1;
        state_next      = S_IDLE;
        res_status_next = ST_OK;
        res_slot_next   = '0;
        res_data_next   = '0;
        res_len_next    = '0;
        if (req.command == CMD_ALLOC) begin
          if (free_count < need || alloc_end > (POS_W+1)'(PAGE_BYTES)) begin
            res_status_next = ST_NOSPACE;
          end else if (slot_total == '0) begin
            done_next      = 1'b0;
            cur_s_next     = '0;
            cur_len_next   = rlen;
            start_pos_next = rec_end;
            append_next    = 1'b1;
            state_next     = S_COMMIT;
          end else begin
            done_next     = 1'b0;
            dir_raddr     = '0;
            scan_ptr_next = '0;
            state_next    = S_SCAN;
          end
        end else if (req.command == CMD_WRITE || req.command == CMD_READ ||
                     req.command == CMD_DELETE) begin
          if (CNT_W'(req.slot) >= slot_total) begin
            res_status_next = ST_RANGE;
          end else begin
            res_len_next = len_rd[11:0];
            if (len_rd == '0) begin
              res_status_next = ST_DELETED;
            end else if (req.command == CMD_DELETE) begin
              done_next      = 1'b0;
              cur_s_next     = SLOT_AW'(req.slot);
              cur_len_next   = len_rd;
              src_next       = from_pos;
              dst_next       = POS_W'(off_rd);
              cnt_next       = span;
              move_left_next = 1'b1;
              mv_pend_next   = 1'b0;
              state_next     = S_MOVE;
            end else if (POS_W'(req.byte_index) >= len_rd) begin
              res_status_next = ST_INDEX;
            end else if (req.command == CMD_WRITE) begin
              page_we    = 1'b1;
              page_waddr = addr[PAGE_AW-1:0];
              page_wdata = req.data_in;
            end else begin
              done_next    = 1'b0;
              page_raddr   = addr[PAGE_AW-1:0];
              cur_len_next = len_rd;
              state_next   = S_RDATA;
            end
          end
        end else if (req.command == CMD_ERASE) begin
          free_count_next = POS_W'(PAGE_BYTES - META_BYTES);
          slot_total_next = '0;
          rec_end_next    = POS_W'(FIRST_OFFSET);
        end
      end

      S_SCAN: begin
        dir_raddr = scan_ptr + SLOT_AW'(1);
        if (len_rd == '0) begin
          cur_s_next     = scan_ptr;
          cur_len_next   = rlen;
          start_pos_next = POS_W'(off_rd);
          append_next    = 1'b0;
          cnt_next       = (rlen == '0) ? '0 : (rec_end - POS_W'(off_rd));
          src_next       = rec_end - POS_W'(1);
          dst_next       = rec_end - POS_W'(1) + rlen;
          move_left_next = 1'b0;
          mv_pend_next   = 1'b0;
          state_next     = S_MOVE;
        end else if (CNT_W'(scan_ptr) == slot_total - CNT_W'(1)) begin
          if (slot_total == CNT_W'(MAX_SLOTS)) begin
            done_next       = 1'b1;
            state_next      = S_IDLE;
            res_status_next = ST_NOSPACE;
            res_slot_next   = '0;
            res_data_next   = '0;
            res_len_next    = '0;
          end else begin
            cur_s_next     = slot_total[SLOT_AW-1:0];
            cur_len_next   = rlen;
            start_pos_next = rec_end;
            append_next    = 1'b1;
            state_next     = S_COMMIT;
          end
        end else begin
          scan_ptr_next = scan_ptr + SLOT_AW'(1);
        end
      end

      S_MOVE: begin
        if (mv_pend) begin
          page_we    = 1'b1;
          page_waddr = mv_waddr;
          page_wdata = page_rd;
        end
        if (cnt != '0) begin
          page_raddr    = src[PAGE_AW-1:0];
          mv_waddr_next = dst[PAGE_AW-1:0];
          mv_pend_next  = 1'b1;
          cnt_next      = cnt - POS_W'(1);
          src_next      = move_left ? src + POS_W'(1) : src - POS_W'(1);
          dst_next      = move_left ? dst + POS_W'(1) : dst - POS_W'(1);
        end else begin
          mv_pend_next = 1'b0;
          if (!mv_pend) begin
            adj_ptr_next  = CNT_W'(cur_s) + CNT_W'(1);
            adj_pend_next = 1'b0;
            state_next    = S_ADJ;
          end
        end
      end

      S_ADJ: begin
        dir_raddr = adj_ptr[SLOT_AW-1:0];
        if (adj_pend) begin
          off_we    = 1'b1;
          dir_waddr = adj_waddr;
          off_wdata = move_left ? off_rd - cur_len[PAGE_AW-1:0]
                                : off_rd + cur_len[PAGE_AW-1:0];
        end
        if (adj_ptr < slot_total) begin
          adj_waddr_next = adj_ptr[SLOT_AW-1:0];
          adj_pend_next  = 1'b1;
          adj_ptr_next   = adj_ptr + CNT_W'(1);
        end else begin
          adj_pend_next = 1'b0;
          if (!adj_pend) begin
            state_next = S_COMMIT;
          end
        end
      end

      S_COMMIT: begin
        done_next       = 1'b1;
        state_next      = S_IDLE;
        res_status_next = ST_OK;
        res_data_next   = '0;
        res_len_next    = cur_len[11:0];
        len_we          = 1'b1;
        dir_waddr       = cur_s;
        if (req.command == CMD_ALLOC) begin
          off_we          = 1'b1;
          off_wdata       = start_pos[PAGE_AW-1:0];
          len_wdata       = cur_len;
          free_count_next = free_count - need;
          rec_end_next    = rec_end + cur_len;
          res_slot_next   = 10'(cur_s);
          if (append) begin
            slot_total_next = slot_total + CNT_W'(1);
          end
        end else begin
          len_wdata       = '0;
          free_count_next = free_count + cur_len;
          rec_end_next    = rec_end - cur_len;
          res_slot_next   = '0;
        end
      end

      S_RDATA: begin
        done_next       = 1'b1;
        state_next      = S_IDLE;
        res_status_next = ST_OK;
        res_slot_next   = '0;
        res_data_next   = page_rd;
        res_len_next    = cur_len[11:0];
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      rec_end    <= POS_W'(FIRST_OFFSET);
      free_count <= POS_W'(PAGE_BYTES - META_BYTES);
      slot_total <= '0;
      mv_pend    <= 1'b0;
      adj_pend   <= 1'b0;
    end else begin
      state      <= state_next;
      done       <= done_next;
      rec_end    <= rec_end_next;
      free_count <= free_count_next;
      slot_total <= slot_total_next;
      mv_pend    <= mv_pend_next;
      adj_pend   <= adj_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    cur_s      <= cur_s_next;
    cur_len    <= cur_len_next;
    start_pos  <= start_pos_next;
    append     <= append_next;
    scan_ptr   <= scan_ptr_next;
    src        <= src_next;
    dst        <= dst_next;
    cnt        <= cnt_next;
    move_left  <= move_left_next;
    mv_waddr   <= mv_waddr_next;
    adj_ptr    <= adj_ptr_next;
    adj_waddr  <= adj_waddr_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_data   <= res_data_next;
    res_len    <= res_len_next;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not start work");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot_total <= CNT_W'(MAX_SLOTS))
    else $error("slot count beyond directory size");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= POS_W'(PAGE_BYTES - META_BYTES))
    else $error("free count beyond page capacity");

endmodule

@@ src/spr_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module spr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ test/slotted_page_record_store_unit_tb.sv @@
// Self-checking bench for slotted_page_record_store_unit: directed and random
// page operations checked against a built-in page model. Depends on spr_pkg.
module slotted_page_record_store_unit_tb;
  import spr_pkg::*;

  logic clk;
  logic rst;
  logic start;
  req_t request;
  logic busy;
  logic done;
  res_t result;

  slotted_page_record_store_unit dut (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .done(done), .result(result)
  );

  logic [7:0]  pg_mem [PAGE_BYTES];
  bit          pg_known [PAGE_BYTES];
  int unsigned dir_off [MAX_SLOTS];
  int unsigned dir_len [MAX_SLOTS];
  int unsigned n_slots;
  int unsigned free_cnt;
  res_t        pending_results [$];
  int          mismatches;
  int          idle_pct;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #1000000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic void page_clear();
    for (int i = 0; i < PAGE_BYTES; i++) pg_known[i] = 0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      dir_off[i] = 0;
      dir_len[i] = 0;
    end
    n_slots = 0;
    free_cnt = PAGE_BYTES - META_BYTES;
  endfunction

  function automatic int unsigned page_end();
    if (n_slots == 0) return FIRST_OFFSET;
    return dir_off[n_slots-1] + dir_len[n_slots-1];
  endfunction

  function automatic void shift_bytes(int unsigned dst, int unsigned src, int unsigned n);
    logic [7:0] tmp [$];
    bit tk [$];
    if (n == 0) return;
    for (int i = 0; i < n; i++) begin
      tmp.push_back(pg_mem[src+i]);
      tk.push_back(pg_known[src+i]);
    end
    for (int i = 0; i < n; i++) begin
      pg_mem[dst+i] = tmp[i];
      pg_known[dst+i] = tk[i];
    end
  endfunction

  function automatic res_t page_apply(req_t rq);
    res_t r;
    int unsigned s, e, st, len, from, addr;
    r = '0;
    if (rq.command == CMD_ALLOC) begin
      len = 32'(rq.record_length);
      e = page_end();
      s = n_slots;
      if (free_cnt < len + SLOT_ENTRY_BYTES || e + len > PAGE_BYTES) begin
        r.status = ST_NOSPACE;
      end else begin
        for (int j = 0; j < n_slots; j++)
          if (dir_len[j] == 0) begin
            s = j;
            break;
          end
        if (s >= MAX_SLOTS) begin
          r.status = ST_NOSPACE;
        end else begin
          st = (s == 0) ? FIRST_OFFSET : dir_off[s-1] + dir_len[s-1];
          if (s < n_slots) begin
            shift_bytes(st + len, st, e - st);
            for (int j = s + 1; j < n_slots; j++) dir_off[j] += len;
          end else begin
            n_slots++;
          end
          dir_off[s] = st;
          dir_len[s] = len;
          free_cnt -= len + SLOT_ENTRY_BYTES;
          r.slot_out = s[9:0];
          r.length_out = len[11:0];
        end
      end
    end else if (rq.command == CMD_WRITE || rq.command == CMD_READ ||
                 rq.command == CMD_DELETE) begin
      s = 32'(rq.slot);
      if (s >= n_slots) begin
        r.status = ST_RANGE;
      end else begin
        len = dir_len[s];
        r.length_out = len[11:0];
        if (rq.command == CMD_DELETE) begin
          if (len == 0) begin
            r.status = ST_DELETED;
          end else begin
            from = dir_off[s] + len;
            e = page_end();
            if (e > from) shift_bytes(dir_off[s], from, e - from);
            for (int j = s + 1; j < n_slots; j++) dir_off[j] -= len;
            dir_len[s] = 0;
            free_cnt += len;
          end
        end else if (len == 0) begin
          r.status = ST_DELETED;
        end else if (32'(rq.byte_index) >= len) begin
          r.status = ST_INDEX;
        end else begin
          addr = dir_off[s] + 32'(rq.byte_index);
          if (rq.command == CMD_WRITE) begin
            pg_mem[addr] = rq.data_in;
            pg_known[addr] = 1;
          end else begin
            r.data_out = pg_mem[addr];
          end
        end
      end
    end else if (rq.command == CMD_ERASE) begin
      page_clear();
    end
    r.free_bytes = free_cnt[11:0];
    r.slots_used = n_slots[10:0];
    return r;
  endfunction

  always @(posedge clk) begin
    res_t x;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result status=%0d", result.status);
        mismatches++;
      end else begin
        x = pending_results.pop_front();
        if (result.status !== x.status) begin
          $error("status exp %0d got %0d", x.status, result.status); mismatches++;
        end
        if (result.slot_out !== x.slot_out) begin
          $error("slot_out exp %0d got %0d", x.slot_out, result.slot_out); mismatches++;
        end
        if (result.data_out !== x.data_out) begin
          $error("data_out exp %0d got %0d", x.data_out, result.data_out); mismatches++;
        end
        if (result.length_out !== x.length_out) begin
          $error("length_out exp %0d got %0d", x.length_out, result.length_out);
          mismatches++;
        end
        if (result.free_bytes !== x.free_bytes) begin
          $error("free_bytes exp %0d got %0d", x.free_bytes, result.free_bytes);
          mismatches++;
        end
        if (result.slots_used !== x.slots_used) begin
          $error("slots_used exp %0d got %0d", x.slots_used, result.slots_used);
          mismatches++;
        end
      end
    end
  end

  // hold start until the transfer; the next send drops it only for idle gaps, the end of the run drops it
  task automatic send(req_t rq);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(page_apply(rq));
  endtask

  function automatic req_t mk(logic [2:0] c, int unsigned s, int unsigned i,
                              int unsigned l, int unsigned d);
    req_t rq;
    rq.command = c;
    rq.slot = s[9:0];
    rq.byte_index = i[11:0];
    rq.record_length = l[11:0];
    rq.data_in = d[7:0];
    return rq;
  endfunction

  // one random op; reads use a written byte of a live record, or write it first
  task automatic rand_op();
    int unsigned k, s, i;
    int live [$];
    k = $urandom_range(99);
    for (int j = 0; j < n_slots; j++) if (dir_len[j] != 0) live.push_back(j);
    if (k < 18) begin
      send(mk(CMD_ALLOC, $urandom, $urandom, ($urandom_range(9) == 0) ?
              $urandom_range(4092) : $urandom_range(40), $urandom));
    end else if (k < 50 && live.size() > 0) begin
      s = live[$urandom_range(live.size()-1)];
      send(mk(CMD_WRITE, s, $urandom_range(dir_len[s]-1), $urandom, $urandom));
    end else if (k < 78 && live.size() > 0) begin
      s = live[$urandom_range(live.size()-1)];
      i = $urandom_range(dir_len[s]-1);
      if (!pg_known[dir_off[s]+i]) send(mk(CMD_WRITE, s, i, $urandom, $urandom));
      send(mk(CMD_READ, s, i, $urandom, $urandom));
    end else if (k < 88 && n_slots > 0) begin
      send(mk(CMD_DELETE, $urandom_range(n_slots-1), $urandom, $urandom, $urandom));
    end else if (k < 97) begin
      // out of range, deleted or beyond length: never touches unwritten bytes
      s = $urandom_range(1023);
      if (s < n_slots && dir_len[s] != 0)
        send(mk($urandom_range(1) ? CMD_WRITE : CMD_READ, s,
                dir_len[s] + $urandom_range(4095 - dir_len[s]), $urandom, $urandom));
      else
        send(mk(3'($urandom_range(CMD_WRITE, CMD_DELETE)), s, $urandom, $urandom,
                $urandom));
    end else if (k < 98) begin
      send(mk(CMD_ERASE, $urandom, $urandom, $urandom, $urandom));
    end else begin
      send(mk(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom));
    end
  endtask

  task automatic test_directed();
    send(mk(CMD_READ, 0, 0, 0, 0));
    send(mk(CMD_ALLOC, 0, 0, 4092, 0));
    send(mk(CMD_ALLOC, 0, 0, 4088, 0));
    send(mk(CMD_WRITE, 0, 0, 0, 8'hff));
    send(mk(CMD_WRITE, 0, 4087, 0, 8'h00));
    send(mk(CMD_READ, 0, 4087, 0, 0));
    send(mk(CMD_READ, 0, 4088, 0, 0));
    send(mk(CMD_ALLOC, 0, 0, 0, 0));
    send(mk(CMD_ERASE, 1023, 4095, 4095, 8'hff));
    send(mk(CMD_ALLOC, 0, 0, 5, 0));
    send(mk(CMD_ALLOC, 0, 0, 0, 0));
    send(mk(CMD_ALLOC, 0, 0, 3, 0));
    send(mk(CMD_WRITE, 1, 0, 0, 1));
    send(mk(CMD_READ, 1, 0, 0, 0));
    send(mk(CMD_WRITE, 2, 2, 0, 8'h5a));
    send(mk(CMD_DELETE, 0, 0, 0, 0));
    send(mk(CMD_DELETE, 0, 0, 0, 0));
    send(mk(CMD_ALLOC, 0, 0, 7, 0));
    send(mk(CMD_READ, 2, 2, 0, 0));
    send(mk(CMD_DELETE, 1023, 0, 0, 0));
    send(mk(3'd7, 1023, 4095, 4095, 8'hff));
    send(mk(CMD_ERASE, 0, 0, 0, 0));
  endtask

  task automatic test_slot_limit();
    for (int j = 0; j < 70; j++) send(mk(CMD_ALLOC, 0, 0, 60, 0));
    send(mk(CMD_DELETE, 1023, 0, 0, 0));
    send(mk(CMD_ERASE, 0, 0, 0, 0));
  endtask

  task automatic test_random(int n);
    for (int j = 0; j < n; j++) begin
      idle_pct = (j >= n / 3 && j < n / 2) ? 0 : 22;
      rand_op();
    end
  endtask

  initial begin
    rst = 1;
    start = 0;
    request = '0;
    mismatches = 0;
    idle_pct = 22;
    page_clear();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_slot_limit();
    test_random(520);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
